### src/ndef_rhp_pkg.sv
`default_nettype none

package ndef_rhp_pkg;

   // Flag masks within the record flags byte.
   localparam logic [7:0] MASK_SR  = 8'h10;
   localparam logic [7:0] MASK_IL  = 8'h08;
   localparam logic [7:0] TNF_BITS = 8'h07;

   // Length of the one external type name that the parser accepts.
   localparam logic [7:0] TYPE_NAME_LEN = 8'd14;

   // Number of bytes in a long payload length field.
   localparam logic [7:0] LONG_PLEN_BYTES = 8'd4;

   // Output byte kinds.
   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_ID      = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;

   // Verdict codes reported on the final byte.
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_HEADER     = 2'd1;
   localparam logic [1:0] ERR_BODY       = 2'd2;
   localparam logic [1:0] ERR_TYPE       = 2'd3;

   // Parser phases, one-hot.
   typedef enum logic [6:0] {
      PH_FLAGS   = 7'b0000001,
      PH_TLEN    = 7'b0000010,
      PH_PLEN    = 7'b0000100,
      PH_IDLEN   = 7'b0001000,
      PH_TYPE    = 7'b0010000,
      PH_ID      = 7'b0100000,
      PH_PAYLOAD = 7'b1000000
   } phase_type;

   // One result transaction as it travels from the parser to the output stage.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_out;
      logic        done_res;
      logic        ok;
      logic [1:0]  error_code;
      logic [2:0]  tnf;
      logic [7:0]  raw_flags;
      logic [7:0]  id_length;
      logic [31:0] payload_used;
   } result_type;

   // Expected characters of the external type name; positions past the end read as zero.
   function automatic logic [7:0] type_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h73;
         4'd1:    c = 8'h74;
         4'd2:    c = 8'h2E;
         4'd3:    c = 8'h63;
         4'd4:    c = 8'h6F;
         4'd5:    c = 8'h6D;
         4'd6:    c = 8'h3A;
         4'd7:    c = 8'h73;
         4'd8:    c = 8'h6D;
         4'd9:    c = 8'h61;
         4'd10:   c = 8'h72;
         4'd11:   c = 8'h74;
         4'd12:   c = 8'h61;
         4'd13:   c = 8'h67;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### src/ndef_record_header_parser.sv
// Each accepted input transaction gives its result transaction from the result register in the next cycle.
// Throughput: one byte per cycle; each byte is parsed by combinational logic into
// a result register, so req_ready stays high while rsp_ready is high.
// Reset: synchronous, active high; the parser returns to the flags phase and the
// result register is emptied. The parser also resets itself after each last byte.
`default_nettype none

module ndef_record_header_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_byte_out,
   output logic             rsp_done_res,
   output logic             rsp_ok,
   output logic [1:0]       rsp_error_code,
   output logic [2:0]       rsp_tnf,
   output logic [7:0]       rsp_raw_flags,
   output logic [7:0]       rsp_id_length,
   output logic [31:0]      rsp_payload_used
);
   import ndef_rhp_pkg::*;

   logic       accept;
   result_type parsed;
   result_type held;

   assign accept = req_valid && req_ready;

   // Byte parser and record state.
   ndef_rhp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .data_byte (req_data_byte),
      .last      (req_last),
      .result    (parsed)
   );

   // Result register towards the response channel.
   ndef_rhp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (parsed),
      .can_load  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (held)
   );

   // Unpack the held result onto the response ports.
   assign rsp_kind         = held.kind;
   assign rsp_byte_out     = held.byte_out;
   assign rsp_done_res     = held.done_res;
   assign rsp_ok           = held.ok;
   assign rsp_error_code   = held.error_code;
   assign rsp_tnf          = held.tnf;
   assign rsp_raw_flags    = held.raw_flags;
   assign rsp_id_length    = held.id_length;
   assign rsp_payload_used = held.payload_used;

endmodule

`default_nettype wire

### src/ndef_rhp_core.sv
`default_nettype none

module ndef_rhp_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [7:0]              data_byte,
   input  wire logic                    last,
   output ndef_rhp_pkg::result_type     result
);
   import ndef_rhp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  field_count_ff, field_count_in;
   logic [7:0]  flags_ff, flags_in;
   logic [7:0]  type_length_ff, type_length_in;
   logic [31:0] declared_ff, declared_in;
   logic [7:0]  id_length_ff, id_length_in;
   logic        type_match_ff, type_match_in;
   logic [31:0] emitted_ff, emitted_in;

   logic        matched_now;
   logic        matched_end;
   logic [7:0]  count_inc;
   phase_type   body_phase;
   logic [1:0]  err;
   logic [1:0]  kind_sel;
   logic [7:0]  byte_sel;

   assign count_inc   = field_count_ff + 8'd1;
   assign matched_now = type_match_ff && (type_length_ff == TYPE_NAME_LEN);

   // First phase of the record body, chosen from the lengths seen in the header.
   always_comb begin
      if (type_length_in != 8'd0) begin
         body_phase = PH_TYPE;
      end else if (id_length_in != 8'd0) begin
         body_phase = PH_ID;
      end else begin
         body_phase = PH_PAYLOAD;
      end
   end

   // Per-byte state update and pass-through selection.
   always_comb begin
      phase_in       = phase_ff;
      field_count_in = field_count_ff;
      flags_in       = flags_ff;
      type_length_in = type_length_ff;
      declared_in    = declared_ff;
      id_length_in   = id_length_ff;
      type_match_in  = type_match_ff;
      emitted_in     = emitted_ff;
      kind_sel       = KIND_NONE;
      byte_sel       = 8'd0;

      unique case (phase_ff)
         PH_TLEN: begin
            type_length_in = data_byte;
            field_count_in = 8'd0;
            declared_in    = 32'd0;
            phase_in       = PH_PLEN;
         end
         PH_PLEN: begin
            declared_in    = {declared_ff[23:0], data_byte};
            field_count_in = count_inc;
            if ((flags_ff & MASK_SR) != 8'd0 || count_inc >= LONG_PLEN_BYTES) begin
               field_count_in = 8'd0;
               if ((flags_ff & MASK_IL) != 8'd0) begin
                  phase_in = PH_IDLEN;
               end else begin
                  phase_in = body_phase;
               end
            end
         end
         PH_IDLEN: begin
            id_length_in   = data_byte;
            field_count_in = 8'd0;
            phase_in       = body_phase;
         end
         PH_TYPE: begin
            if (field_count_ff >= TYPE_NAME_LEN ||
                data_byte != type_char(field_count_ff[3:0])) begin
               type_match_in = 1'b0;
            end
            field_count_in = count_inc;
            if (count_inc >= type_length_ff) begin
               field_count_in = 8'd0;
               phase_in = (id_length_ff != 8'd0) ? PH_ID : PH_PAYLOAD;
            end
         end
         PH_ID: begin
            kind_sel       = KIND_ID;
            byte_sel       = data_byte;
            field_count_in = count_inc;
            if (count_inc >= id_length_ff) begin
               field_count_in = 8'd0;
               phase_in       = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (matched_now && emitted_ff < declared_ff) begin
               kind_sel   = KIND_PAYLOAD;
               byte_sel   = data_byte;
               emitted_in = emitted_ff + 32'd1;
            end
         end
         default: begin
            // Flags phase.
            flags_in = data_byte;
            phase_in = PH_TLEN;
         end
      endcase
   end

   // Verdict for the final byte, taken from the state after this byte.
   assign matched_end = type_match_in && (type_length_in == TYPE_NAME_LEN);

   always_comb begin
      if (phase_in == PH_FLAGS || phase_in == PH_TLEN || phase_in == PH_PLEN ||
          phase_in == PH_IDLEN) begin
         err = ERR_HEADER;
      end else if (phase_in == PH_TYPE || phase_in == PH_ID) begin
         err = ERR_BODY;
      end else if (!matched_end) begin
         err = ERR_TYPE;
      end else begin
         err = ERR_NONE;
      end
   end

   // The passed byte goes out on every result; the summary fields only on the final byte.
   always_comb begin
      result          = '0;
      result.kind     = kind_sel;
      result.byte_out = byte_sel;
      result.done_res = last;
      if (last) begin
         result.ok           = (err == ERR_NONE);
         result.error_code   = err;
         result.tnf          = flags_in[2:0] & TNF_BITS[2:0];
         result.raw_flags    = flags_in;
         result.id_length    = id_length_in;
         result.payload_used = (err == ERR_NONE) ? emitted_in : 32'd0;
      end
   end

   // State registers; the final byte of a record returns everything to reset values.
   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         phase_ff       <= PH_FLAGS;
         field_count_ff <= 8'd0;
         flags_ff       <= 8'd0;
         type_length_ff <= 8'd0;
         declared_ff    <= 32'd0;
         id_length_ff   <= 8'd0;
         type_match_ff  <= 1'b1;
         emitted_ff     <= 32'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         field_count_ff <= field_count_in;
         flags_ff       <= flags_in;
         type_length_ff <= type_length_in;
         declared_ff    <= declared_in;
         id_length_ff   <= id_length_in;
         type_match_ff  <= type_match_in;
         emitted_ff     <= emitted_in;
      end
   end

endmodule

`default_nettype wire

### src/ndef_rhp_out_stage.sv
`default_nettype none

module ndef_rhp_out_stage (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  ndef_rhp_pkg::result_type     load_data,
   output logic                         can_load,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output ndef_rhp_pkg::result_type     out_data
);
   import ndef_rhp_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   // A new result may enter when the register is empty or is being emptied now.
   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

`default_nettype wire

### verif/tb_ndef_record_header_parser.sv
`default_nettype none

module tb_ndef_record_header_parser;

   import ndef_rhp_pkg::*;

   // External type name that the parser accepts, first character in the top byte.
   localparam logic [111:0] EXT_TYPE_NAME = 112'h7374_2E63_6F6D_3A73_6D61_7274_6167;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_byte_out;
   logic        rsp_done_res;
   logic        rsp_ok;
   logic [1:0]  rsp_error_code;
   logic [2:0]  rsp_tnf;
   logic [7:0]  rsp_raw_flags;
   logic [7:0]  rsp_id_length;
   logic [31:0] rsp_payload_used;

   // Shadow copy of the parser state.
   phase_type   ps_phase;
   logic [7:0]  ps_count;
   logic [7:0]  ps_flags;
   logic [7:0]  ps_type_len;
   logic [31:0] ps_declared;
   logic [7:0]  ps_id_len;
   logic        ps_type_ok;
   logic [31:0] ps_emitted;

   result_type  parse_results_q[$];
   logic [7:0]  record_q[$];
   int          fail_count = 0;
   int          bytes_sent = 0;
   int          stall_left = 0;
   bit          idle_on = 1'b1;

   ndef_record_header_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_done_res    (rsp_done_res),
      .rsp_ok          (rsp_ok),
      .rsp_error_code  (rsp_error_code),
      .rsp_tnf         (rsp_tnf),
      .rsp_raw_flags   (rsp_raw_flags),
      .rsp_id_length   (rsp_id_length),
      .rsp_payload_used(rsp_payload_used)
   );

   always #5 clock = ~clock;

   // Character of the external type name at a given position.
   function automatic logic [7:0] ext_type_char(input int idx);
      return EXT_TYPE_NAME[8*(13-idx) +: 8];
   endfunction

   // Appends one byte to the record being assembled.
   function automatic void add_record_byte(input logic [7:0] b);
      record_q = {record_q, b};
   endfunction

   function automatic void clear_parser_state();
      ps_phase    = PH_FLAGS;
      ps_count    = 8'd0;
      ps_flags    = 8'd0;
      ps_type_len = 8'd0;
      ps_declared = 32'd0;
      ps_id_len   = 8'd0;
      ps_type_ok  = 1'b1;
      ps_emitted  = 32'd0;
   endfunction

   // The body starts with the type, then the identifier, then the payload;
   // empty fields are skipped.
   function automatic void enter_record_body();
      ps_count = 8'd0;
      if (ps_type_len != 8'd0) begin
         ps_phase = PH_TYPE;
      end else if (ps_id_len != 8'd0) begin
         ps_phase = PH_ID;
      end else begin
         ps_phase = PH_PAYLOAD;
      end
   endfunction

   // Advances the shadow parser by one byte and returns the result that byte should give.
   function automatic result_type parse_record_byte(input logic [7:0] b, input logic is_last);
      result_type r;
      logic       matched;
      logic [1:0] verdict;
      int         idx;
      r = '0;
      matched = ps_type_ok && (ps_type_len == TYPE_NAME_LEN);
      case (ps_phase)
         PH_FLAGS: begin
            ps_flags = b;
            ps_phase = PH_TLEN;
         end
         PH_TLEN: begin
            ps_type_len = b;
            ps_count = 8'd0;
            ps_declared = 32'd0;
            ps_phase = PH_PLEN;
         end
         PH_PLEN: begin
            ps_declared = {ps_declared[23:0], b};
            ps_count++;
            if ((ps_flags & MASK_SR) != 8'h00 || ps_count >= LONG_PLEN_BYTES) begin
               ps_count = 8'd0;
               if ((ps_flags & MASK_IL) != 8'h00) begin
                  ps_phase = PH_IDLEN;
               end else begin
                  enter_record_body();
               end
            end
         end
         PH_IDLEN: begin
            ps_id_len = b;
            enter_record_body();
         end
         PH_TYPE: begin
            idx = int'(ps_count);
            if (idx >= TYPE_NAME_LEN) begin
               ps_type_ok = 1'b0;
            end else if (b != ext_type_char(idx)) begin
               ps_type_ok = 1'b0;
            end
            ps_count++;
            if (ps_count >= ps_type_len) begin
               ps_count = 8'd0;
               ps_phase = (ps_id_len != 8'd0) ? PH_ID : PH_PAYLOAD;
            end
         end
         PH_ID: begin
            r.kind = KIND_ID;
            r.byte_out = b;
            ps_count++;
            if (ps_count >= ps_id_len) begin
               ps_count = 8'd0;
               ps_phase = PH_PAYLOAD;
            end
         end
         default: begin
            if (matched && ps_emitted < ps_declared) begin
               r.kind = KIND_PAYLOAD;
               r.byte_out = b;
               ps_emitted++;
            end
         end
      endcase

      // The final byte carries the verdict and restarts the parser.
      if (is_last) begin
         matched = ps_type_ok && (ps_type_len == TYPE_NAME_LEN);
         case (ps_phase)
            PH_FLAGS, PH_TLEN, PH_PLEN, PH_IDLEN: verdict = ERR_HEADER;
            PH_TYPE, PH_ID:                      verdict = ERR_BODY;
            default:                             verdict = matched ? ERR_NONE : ERR_TYPE;
         endcase
         r.done_res = 1'b1;
         r.ok = (verdict == ERR_NONE);
         r.error_code = verdict;
         r.tnf = ps_flags[2:0];
         r.raw_flags = ps_flags;
         r.id_length = ps_id_len;
         r.payload_used = (verdict == ERR_NONE) ? ps_emitted : 32'd0;
         clear_parser_state();
      end
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("error at %0t: %s", $time, msg);
      end
   endfunction

   function automatic string show_result(input result_type r);
      return $sformatf({"kind=%0d byte=%02h done=%0b ok=%0b err=%0d tnf=%0d ",
                        "flags=%02h idlen=%0d used=%0d"},
                       r.kind, r.byte_out, r.done_res, r.ok, r.error_code, r.tnf,
                       r.raw_flags, r.id_length, r.payload_used);
   endfunction

   // Idle stretch length: mostly short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Result checker and receiver stalls.
   always @(posedge clock) begin : result_check
      result_type seen;
      result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.kind = rsp_kind;
            seen.byte_out = rsp_byte_out;
            seen.done_res = rsp_done_res;
            seen.ok = rsp_ok;
            seen.error_code = rsp_error_code;
            seen.tnf = rsp_tnf;
            seen.raw_flags = rsp_raw_flags;
            seen.id_length = rsp_id_length;
            seen.payload_used = rsp_payload_used;
            if (parse_results_q.size() == 0) begin
               note_failure({"result transaction with none outstanding: ",
                             show_result(seen)});
            end else begin
               want = parse_results_q.pop_front();
               if (seen.kind !== want.kind || seen.byte_out !== want.byte_out ||
                   seen.done_res !== want.done_res || seen.ok !== want.ok ||
                   seen.error_code !== want.error_code || seen.tnf !== want.tnf ||
                   seen.raw_flags !== want.raw_flags || seen.id_length !== want.id_length ||
                   seen.payload_used !== want.payload_used) begin
                  note_failure({"mismatch, expected ", show_result(want),
                                " got ", show_result(seen)});
               end
            end
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = idle_length() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sends one byte transaction and records the result it should give once accepted.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      int         gap;
      result_type predicted;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= is_last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = parse_record_byte(b, is_last);
      parse_results_q = {parse_results_q, predicted};
      bytes_sent++;
   endtask

   // Streams the bytes gathered in record_q, marking the final one as last.
   task automatic send_record();
      int i;
      for (i = 0; i < record_q.size(); i++) begin
         send_byte(record_q[i], i == record_q.size() - 1);
      end
      record_q.delete();
   endtask

   task automatic push_type_name();
      int i;
      for (i = 0; i < TYPE_NAME_LEN; i++) begin
         add_record_byte(ext_type_char(i));
      end
   endtask

   // Records that end before the header is complete.
   task automatic test_short_header();
      add_record_byte(8'hFF);
      send_record();
      add_record_byte(8'h00);
      add_record_byte(8'h0E);
      send_record();
      add_record_byte(8'h47);
      add_record_byte(8'h0E);
      add_record_byte(8'h00);
      add_record_byte(8'h01);
      send_record();
   endtask

   // Records that end inside the type, and inside the identifier after one byte has passed.
   task automatic test_body_truncation();
      add_record_byte(8'h10);
      add_record_byte(8'h0E);
      add_record_byte(8'h00);
      add_record_byte(8'h73);
      send_record();
      add_record_byte(8'h18);
      add_record_byte(8'h00);
      add_record_byte(8'h00);
      add_record_byte(8'h02);
      add_record_byte(8'h11);
      send_record();
   endtask

   // A well-formed record with an identifier and a byte beyond the declared payload.
   task automatic test_accepted_record();
      add_record_byte(8'h1C);
      add_record_byte(8'h0E);
      add_record_byte(8'h02);
      add_record_byte(8'h01);
      push_type_name();
      add_record_byte(8'hA5);
      add_record_byte(8'h00);
      add_record_byte(8'hFF);
      add_record_byte(8'h5A);
      send_record();
   endtask

   // Long-form length at its maximum with a type of the wrong length: no payload may pass.
   task automatic test_type_mismatch();
      add_record_byte(8'hE7);
      add_record_byte(8'h01);
      repeat (4) add_record_byte(8'hFF);
      add_record_byte(8'h73);
      add_record_byte(8'h33);
      send_record();
   endtask

   // Mostly well-formed records with random content, some corrupted or cut, some pure noise.
   task automatic send_random_record();
      logic [7:0]  flags;
      logic [7:0]  tlen;
      logic [7:0]  idlen;
      logic [31:0] declared;
      int          head_len;
      int          avail;
      int          cut;
      int          i;
      int          r;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6)) add_record_byte(8'($urandom_range(0, 255)));
      end else begin
         flags = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 9))
            0:       tlen = 8'd0;
            1:       tlen = 8'd13;
            2:       tlen = 8'd15;
            3:       tlen = ($urandom_range(0, 19) == 0) ? 8'd255 : 8'($urandom_range(1, 30));
            default: tlen = TYPE_NAME_LEN;
         endcase
         if ((flags & MASK_SR) != 8'h00) begin
            declared = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 255)
                                                   : $urandom_range(0, 20);
         end else begin
            case ($urandom_range(0, 9))
               0:       declared = 32'hFFFF_FFFF;
               1, 2:    declared = $urandom;
               default: declared = $urandom_range(0, 20);
            endcase
         end
         r = $urandom_range(0, 99);
         if (r < 88) begin
            idlen = 8'($urandom_range(0, 4));
         end else if (r < 98) begin
            idlen = 8'($urandom_range(5, 20));
         end else begin
            idlen = 8'd255;
         end

         // Header fields.
         add_record_byte(flags);
         add_record_byte(tlen);
         if ((flags & MASK_SR) != 8'h00) begin
            add_record_byte(declared[7:0]);
         end else begin
            for (i = 3; i >= 0; i--) add_record_byte(declared[8*i +: 8]);
         end
         if ((flags & MASK_IL) != 8'h00) begin
            add_record_byte(idlen);
         end
         head_len = record_q.size();

         // Type, with the odd corrupted character.
         for (i = 0; i < tlen; i++) begin
            add_record_byte((i < TYPE_NAME_LEN) ? ext_type_char(i)
                                                : 8'($urandom_range(0, 255)));
         end
         if (tlen != 8'd0 && $urandom_range(0, 9) == 0) begin
            i = head_len + $urandom_range(0, tlen - 1);
            record_q[i] = record_q[i] ^ 8'($urandom_range(1, 255));
         end

         // Identifier and payload bytes.
         if ((flags & MASK_IL) != 8'h00) begin
            repeat (idlen) add_record_byte(8'($urandom_range(0, 255)));
         end
         avail = (declared <= 32'd20) ? $urandom_range(0, declared + 3) : $urandom_range(0, 24);
         repeat (avail) add_record_byte(8'($urandom_range(0, 255)));

         // Occasionally the stream stops early.
         if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, record_q.size());
            record_q = record_q[0:cut-1];
         end
      end
      send_record();
   endtask

   task automatic test_random_records();
      int start_count;
      start_count = bytes_sent;
      while (bytes_sent - start_count < 1600) begin
         // Quiet stretches without any idling on either side.
         idle_on = ($urandom_range(0, 3) != 0);
         send_random_record();
      end
      idle_on = 1'b1;
   endtask

   initial begin : main
      int waited;
      clear_parser_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_short_header();
      test_body_truncation();
      test_accepted_record();
      test_type_mismatch();
      test_random_records();

      // Drain outstanding results, then allow for the result register.
      req_valid <= 1'b0;
      waited = 0;
      while (parse_results_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (parse_results_q.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", parse_results_q.size()));
      end
      if (fail_count == 0) begin
         $display("** ndef_record_header_parser: PASSED **");
      end else begin
         $display("** ndef_record_header_parser: FAILED **");
      end
      $finish;
   end

   // Overall time limit.
   initial begin
      #10_000_000;
      $display("** ndef_record_header_parser: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire
